/* rtl/clcd_pkg.sv */
`default_nettype none

package clcd_pkg;

   // Panel operation codes as they arrive on the request channel.
   typedef enum logic [2:0] {
      OP_DATA    = 3'd0,
      OP_COMMAND = 3'd1,
      OP_CURSOR  = 3'd2,
      OP_DISPCTL = 3'd3,
      OP_INIT    = 3'd4,
      OP_GLYPH   = 3'd5
   } op_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_COLUMNS   = 3'd0;
   localparam logic [2:0] REG_ROWS      = 3'd1;
   localparam logic [2:0] REG_ADDRESS   = 3'd2;
   localparam logic [2:0] REG_BACKLIGHT = 3'd3;

   // Panel constants.
   localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_HOME        = 8'h02;
   localparam logic [7:0] LINE1_START     = 8'h40;
   localparam logic [7:0] LINE2_START_20  = 8'h14;
   localparam logic [7:0] LINE3_START_20  = 8'h54;
   localparam logic [2:0] FLAGS_RESET     = 3'b100;
   localparam logic [3:0] NIBBLE_WAKE     = 4'h3;
   localparam logic [3:0] NIBBLE_4BIT     = 4'h2;

   // Command bytes sent after the nibble wake-up part of the init sequence.
   localparam logic [7:0] INIT_CMDS [4] = '{8'h28, 8'h0C, 8'h01, 8'h06};

   // Waits in milliseconds.
   localparam logic [5:0] WAIT_POWER_ON  = 6'd50;
   localparam logic [2:0] WAIT_WAKE_LONG = 3'd5;
   localparam logic [2:0] WAIT_WAKE      = 3'd1;
   localparam logic [2:0] WAIT_CLEAR     = 3'd2;

   // Result index of the final result of the long operations.
   localparam logic [5:0] INIT_LAST  = 6'd23;
   localparam logic [5:0] GLYPH_LAST = 6'd35;

   // One operation as held while its results are produced.
   typedef struct packed {
      op_type      op;
      logic [7:0]  cmd;        // command or data byte, already resolved
      logic        err;        // invalid cursor position
      logic        long_wait;  // clear or home command
      logic [63:0] glyph;
   } item_type;

   // One result before the address is attached.
   typedef struct packed {
      logic [7:0] expander_byte;
      logic [5:0] wait_before_ms;
      logic [2:0] wait_after_ms;
      logic       error;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

/* rtl/clcd_result_gen.sv */
`default_nettype none

module clcd_result_gen (
   input  clcd_pkg::item_type   item,
   input  logic [5:0]           index,
   input  logic                 backlight,
   output clcd_pkg::result_type result
);
   import clcd_pkg::*;

   logic [3:0] nibble;
   logic       rs;
   logic       enable;
   logic [7:0] cur_byte;
   logic [3:0] slot;
   logic [3:0] init_step;
   logic [7:0] init_cmd;

   // Pick the nibble, strobe phase and waits for one result index.
   always_comb begin
      nibble                = '0;
      rs                    = 1'b0;
      enable                = 1'b0;
      cur_byte              = item.cmd;
      slot                  = index[5:2] - 4'd1;
      init_step             = index[3:0] - 4'd8;
      init_cmd              = INIT_CMDS[init_step[3:2]];
      result.wait_before_ms = '0;
      result.wait_after_ms  = '0;
      result.error          = 1'b0;
      result.last           = 1'b0;
      case (item.op)
         OP_DATA, OP_COMMAND, OP_CURSOR, OP_DISPCTL: begin
            if (item.err) begin
               result.error = 1'b1;
               result.last  = 1'b1;
            end else begin
               rs          = (item.op == OP_DATA);
               nibble      = index[1] ? cur_byte[3:0] : cur_byte[7:4];
               enable      = ~index[0];
               result.last = (index[1:0] == 2'd3);
               if (result.last && item.long_wait) begin
                  result.wait_after_ms = WAIT_CLEAR;
               end
            end
         end
         OP_GLYPH: begin
            // The first byte is the glyph address command, then eight pattern rows.
            if (index[5:2] != 4'd0) begin
               cur_byte = item.glyph[8*slot[2:0] +: 8];
               rs       = 1'b1;
            end
            nibble      = index[1] ? cur_byte[3:0] : cur_byte[7:4];
            enable      = ~index[0];
            result.last = (index == GLYPH_LAST);
         end
         OP_INIT: begin
            enable = ~index[0];
            if (index[5:3] == 3'd0) begin
               // Wake-up nibbles: three times 3, then 2 to enter four-bit mode.
               nibble = (index[2:1] == 2'd3) ? NIBBLE_4BIT : NIBBLE_WAKE;
               if (index == 6'd0) begin
                  result.wait_before_ms = WAIT_POWER_ON;
               end
               if (index[0]) begin
                  result.wait_after_ms = (index[2:1] == 2'd0) ? WAIT_WAKE_LONG : WAIT_WAKE;
               end
            end else begin
               nibble = init_step[1] ? init_cmd[3:0] : init_cmd[7:4];
               if (init_step == 4'd11) begin
                  result.wait_after_ms = WAIT_CLEAR;
               end
            end
            result.last = (index == INIT_LAST);
         end
         default: begin
         end
      endcase
      result.expander_byte = result.error ? 8'h00 : {nibble, backlight, enable, 1'b0, rs};
   end

endmodule

`default_nettype wire

/* rtl/char_lcd_i2c_expander_sequencer.sv */
// Timing: an accepted item is registered, then each of its results passes through the output
// register, one result per cycle while rsp_ready does not stall. An item has as many results as
// listed here: 4 for data, command, cursor and display control, 1 for a bad cursor position, 24
// for init, 36 for a glyph; a single result counter walks the held item. Ops 6 and 7 give none.
// Reset: synchronous, active high; registers return to 16 columns, 2 rows, address 39,
// backlight on, and display flags to display on, cursor off, blink off.
`default_nettype none

module char_lcd_i2c_expander_sequencer (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_value,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_column,
   input  logic [1:0]  req_control_bit,
   input  logic        req_control_value,
   input  logic [63:0] req_glyph,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_expander_byte,
   output logic [7:0]  rsp_write_address,
   output logic [5:0]  rsp_wait_before_ms,
   output logic [2:0]  rsp_wait_after_ms,
   output logic        rsp_error,
   output logic        rsp_last,
   // Configuration port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import clcd_pkg::*;

   logic [5:0] columns_ff;
   logic [2:0] rows_ff;
   logic [6:0] address_ff;
   logic       backlight_ff;
   logic [2:0] flags_ff;
   logic [2:0] flags_in;

   item_type   item_ff;
   item_type   item_in;
   logic       busy_ff;
   logic [5:0] count_ff;

   result_type gen_result;
   logic       advance;
   logic       req_take;
   logic       op_known;

   logic [7:0] line_start;
   logic [7:0] cursor_addr;
   logic       cursor_bad;

   logic       rsp_valid_ff;
   result_type rsp_ff;
   logic [7:0] rsp_address_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= 6'd16;
         rows_ff      <= 3'd2;
         address_ff   <= 7'd39;
         backlight_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COLUMNS:   columns_ff   <= csr_data[5:0];
            REG_ROWS:      rows_ff      <= csr_data[2:0];
            REG_ADDRESS:   address_ff   <= csr_data[6:0];
            REG_BACKLIGHT: backlight_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Cursor address: line start plus column, checked against the panel size.
   always_comb begin
      cursor_bad = (req_row >= {5'd0, rows_ff}) || (req_column >= {2'd0, columns_ff}) ||
                   (req_row >= 8'd4);
      case (req_row[1:0])
         2'd0:    line_start = 8'h00;
         2'd1:    line_start = LINE1_START;
         2'd2:    line_start = (rows_ff == 3'd4 && columns_ff == 6'd20) ?
                               LINE2_START_20 : {2'd0, columns_ff};
         default: line_start = (rows_ff == 3'd4 && columns_ff == 6'd20) ?
                               LINE3_START_20 : (LINE1_START + {2'd0, columns_ff});
      endcase
      cursor_addr = line_start + req_column;
   end

   // Resolve the first byte of an item and the new display flags at acceptance.
   always_comb begin
      flags_in          = flags_ff;
      op_known          = 1'b1;
      item_in.op        = op_type'(req_op);
      item_in.cmd       = req_value;
      item_in.err       = 1'b0;
      item_in.long_wait = 1'b0;
      item_in.glyph     = req_glyph;
      case (req_op)
         OP_DATA: begin
         end
         OP_COMMAND: begin
            item_in.long_wait = (req_value == CMD_CLEAR) || (req_value == CMD_HOME);
         end
         OP_CURSOR: begin
            item_in.err = cursor_bad;
            item_in.cmd = CMD_SET_DDRAM | cursor_addr;
         end
         OP_DISPCTL: begin
            if (req_control_bit != 2'd3) begin
               flags_in[req_control_bit] = req_control_value;
            end
            item_in.cmd = {5'b00001, flags_in};
         end
         OP_INIT: begin
            flags_in = FLAGS_RESET;
         end
         OP_GLYPH: begin
            item_in.cmd = {2'b01, req_value[2:0], 3'b000};
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

   clcd_result_gen u_gen (
      .item      (item_ff),
      .index     (count_ff),
      .backlight (backlight_ff),
      .result    (gen_result)
   );

   // A result moves into the output register when that register is free or being drained.
   assign advance   = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff || (advance && gen_result.last);
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         flags_ff <= FLAGS_RESET;
      end else begin
         if (req_take) begin
            busy_ff  <= op_known;
            count_ff <= '0;
            flags_ff <= flags_in;
         end else if (advance) begin
            if (gen_result.last) begin
               busy_ff <= 1'b0;
            end
            count_ff <= count_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff         <= gen_result;
         rsp_address_ff <= {address_ff, 1'b0};
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_expander_byte  = rsp_ff.expander_byte;
   assign rsp_write_address  = rsp_address_ff;
   assign rsp_wait_before_ms = rsp_ff.wait_before_ms;
   assign rsp_wait_after_ms  = rsp_ff.wait_after_ms;
   assign rsp_error          = rsp_ff.error;
   assign rsp_last           = rsp_ff.last;

   // An error result stands alone and carries no panel byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.last && (rsp_ff.expander_byte == 8'h00))
      else $error("error result is not a lone empty transfer");

   // The result counter never runs past the longest operation.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff <= GLYPH_LAST)
      else $error("result counter out of range");

   // A new item only replaces a busy one when its final result is moving out.
   assert property (@(posedge clock) disable iff (reset)
      req_take && busy_ff |-> advance && gen_result.last)
      else $error("item replaced before its final result");

   // Reset leaves the display flags at display on, cursor and blink off.
   assert property (@(posedge clock)
      reset |=> flags_ff == FLAGS_RESET)
      else $error("display flags wrong after reset");

endmodule

`default_nettype wire
